// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own behaviour (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/iidl_pkg.sv =====
// Package for the indexed insert/delete list: sizes, codes and interface types.
package iidl_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;

  // Fixed field widths of the request and result.
  localparam int KIND_W   = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int RDVAL_W  = 32;
  localparam int COUNT_W  = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_POP    = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RDVAL_W-1:0]  read_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } out_res_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      pos;
    logic [WORD_WIDTH-1:0] word;
  } cell_ctrl_t;

  // Outcome of the decoded request, handed to the result register.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                rd_ok;
    logic [IDX_W-1:0]    rd_idx;
    logic [CNT_W-1:0]    count_nxt;
  } req_stat_t;

endpackage

// ===== rtl/iidl_cell.sv =====
// One storage cell of the list chain: holds, loads, or takes a neighbour's word.
module iidl_cell (
  input  logic                              clk,
  input  iidl_pkg::cell_ctrl_t              ctrl,
  input  logic [iidl_pkg::IDX_W-1:0]        idx,
  input  logic [iidl_pkg::WORD_WIDTH-1:0]   left_word,
  input  logic [iidl_pkg::WORD_WIDTH-1:0]   right_word,
  output logic [iidl_pkg::WORD_WIDTH-1:0]   word
);

  logic [iidl_pkg::WORD_WIDTH-1:0] word_r;
  logic [iidl_pkg::WORD_WIDTH-1:0] word_nxt;

  // An insert loads the new word at its position and moves cells above it up;
  // a delete pulls every cell at or above its position down by one.
  always_comb begin
    word_nxt = word_r;
    if (ctrl.ins) begin
      if (idx == ctrl.pos) begin
        word_nxt = ctrl.word;
      end else if (idx > ctrl.pos) begin
        word_nxt = left_word;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.pos) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== rtl/iidl_ctrl.sv =====
// Request decoder and entry counter of the list.
module iidl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_go,
  input  iidl_pkg::in_req_t    req,
  output iidl_pkg::cell_ctrl_t ctrl,
  output iidl_pkg::req_stat_t  stat
);

  logic [iidl_pkg::CNT_W-1:0] count_r;
  logic [iidl_pkg::CNT_W-1:0] count_nxt;
  logic [iidl_pkg::CMP_W-1:0] pos_ext;
  logic [iidl_pkg::CMP_W-1:0] cnt_ext;
  logic                       full;
  logic                       empty;
  logic                       pos_below;

  assign pos_ext   = iidl_pkg::CMP_W'(req.position);
  assign cnt_ext   = iidl_pkg::CMP_W'(count_r);
  assign full      = (cnt_ext == iidl_pkg::CMP_W'(iidl_pkg::CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_below = (pos_ext < cnt_ext);

  always_comb begin
    count_nxt      = count_r;
    ctrl.ins       = 1'b0;
    ctrl.del       = 1'b0;
    ctrl.pos       = iidl_pkg::IDX_W'(req.position);
    ctrl.word      = iidl_pkg::WORD_WIDTH'(req.value);
    stat.status    = iidl_pkg::ST_OK;
    stat.rd_ok     = 1'b0;
    stat.rd_idx    = iidl_pkg::IDX_W'(req.position);
    unique case (req.kind) inside
      iidl_pkg::KIND_PUSH, iidl_pkg::KIND_INSERT: begin
        if (full) begin
          stat.status = iidl_pkg::ST_FULL;
        end else begin
          ctrl.ins  = req_go;
          // A push, or an insert past the end, appends.
          if (req.kind == iidl_pkg::KIND_PUSH || pos_ext > cnt_ext) begin
            ctrl.pos = iidl_pkg::IDX_W'(count_r);
          end
          count_nxt = iidl_pkg::CNT_W'(count_r + iidl_pkg::CNT_W'(1));
        end
      end
      iidl_pkg::KIND_POP, iidl_pkg::KIND_DELETE: begin
        if (empty) begin
          stat.status = iidl_pkg::ST_EMPTY;
        end else begin
          ctrl.del = req_go;
          // A pop, or a delete at or past the end, drops the last entry.
          if (!(req.kind == iidl_pkg::KIND_DELETE && pos_below)) begin
            ctrl.pos = iidl_pkg::IDX_W'(count_r - iidl_pkg::CNT_W'(1));
          end
          count_nxt = iidl_pkg::CNT_W'(count_r - iidl_pkg::CNT_W'(1));
        end
      end
      iidl_pkg::KIND_READ: begin
        if (pos_below) begin
          stat.rd_ok = 1'b1;
        end else begin
          stat.status = iidl_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    stat.count_nxt = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (req_go) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/indexed_insert_delete_list_unit.sv =====
// Top level of the indexed insert/delete list: cell chain, read port, result register.
//
// A bounded ordered list of words. A request is presented on in_req with start
// high; it is taken at any rising edge where start is high and busy is low.
// Kinds are push, insert at position, pop, delete at position and read at
// position. Insert and delete move every affected entry at once: each stored
// word sits in its own cell and, in the cycle of the request, either holds,
// loads the new word, or takes the word of its left or right neighbour.
// busy never rises, so one request is taken in every cycle; the rate is set by
// the shift of the cell chain, which moves every affected entry at once.
// Exactly one result follows each request, on out_res with out_valid high for
// one cycle, in the cycle after the request is taken. The receiver cannot stall
// the result, so none is held back.
// The result gives a status, the word read (zero unless a read succeeds), the
// entry count after the request and an empty flag.
// Reset (rst_n low at a rising edge) empties the list and drops any pending
// result; stored words are not cleared and are never read before being written.
`include "assert_macros.svh"

module indexed_insert_delete_list_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  iidl_pkg::in_req_t  in_req,
  output logic               out_valid,
  output iidl_pkg::out_res_t out_res
);

  iidl_pkg::cell_ctrl_t            ctrl;
  iidl_pkg::req_stat_t             stat;
  logic                            req_go;
  logic [iidl_pkg::WORD_WIDTH-1:0] cell_word [iidl_pkg::CAPACITY];
  logic [iidl_pkg::WORD_WIDTH-1:0] rd_word;
  logic [iidl_pkg::RDVAL_W-1:0]    rd_wide;
  logic                            out_valid_r;
  iidl_pkg::out_res_t              out_res_r;
  iidl_pkg::out_res_t              out_res_nxt;

  // Every request completes in its own cycle, so the block is never busy.
  assign busy   = 1'b0;
  assign req_go = start && !busy;

  iidl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .req_go(req_go),
    .req   (in_req),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // The chain: cell i sees cell i-1 on its left and cell i+1 on its right.
  // The ends see zero; those inputs only feed entries beyond the count.
  for (genvar i = 0; i < iidl_pkg::CAPACITY; i++) begin : g_cell
    logic [iidl_pkg::WORD_WIDTH-1:0] left_w;
    logic [iidl_pkg::WORD_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == iidl_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end
    iidl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (iidl_pkg::IDX_W'(i)),
      .left_word (left_w),
      .right_word(right_w),
      .word      (cell_word[i])
    );
  end

  // A read sees the list as it stood before the request.
  assign rd_word = cell_word[stat.rd_idx];
  assign rd_wide = iidl_pkg::RDVAL_W'(rd_word);

  always_comb begin
    out_res_nxt.status     = stat.status;
    out_res_nxt.read_value = stat.rd_ok ? rd_wide : '0;
    out_res_nxt.count      = iidl_pkg::COUNT_W'(stat.count_nxt);
    out_res_nxt.is_empty   = (stat.count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_go;
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `ASSERT_CLK(a_result_follows, req_go |=> out_valid, "request taken without a result")
  `ASSERT_CLK(a_no_spurious, !req_go |=> !out_valid, "result without a request")
  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result strobe after reset")
  `ASSERT_CLK(a_read_zero,
              (out_valid && out_res.status != iidl_pkg::ST_OK) |-> (out_res.read_value == '0),
              "read value set on a failed request")

endmodule

// ===== sim/tb_indexed_insert_delete_list_unit.sv =====
// Self-checking testbench for the indexed insert/delete list unit.
`timescale 1ns / 100ps

module tb_indexed_insert_delete_list_unit;
  import iidl_pkg::*;

  // The limit is many times the length of the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 550;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_valid;
  out_res_t out_res;

  indexed_insert_delete_list_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting to be presented, and the responses the list owes us, oldest first.
  in_req_t  queued_requests[$];
  out_res_t due_responses[$];

  // Our own copy of the list, advanced once for every request the block takes.
  logic [WORD_WIDTH-1:0] list_words[CAPACITY];
  int                    list_len = 0;

  int accepted_n = 0;
  int mismatch_n = 0;
  int cycle_n = 0;

  // Running length of the list as the stimulus plan will leave it; the length
  // depends only on the kinds, so the plan can steer towards full and empty.
  int planned_len = 0;

  // Applies one request to the shadow list and returns the response it earns.
  function automatic out_res_t apply_to_list(in_req_t req);
    out_res_t res;
    int       at;
    int       i;
    res = '0;
    at = req.position;
    case (req.kind)
      KIND_PUSH, KIND_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // An insert at or past the end behaves as a push.
          if (req.kind == KIND_PUSH || at > list_len) at = list_len;
          for (i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = req.value[WORD_WIDTH-1:0];
          list_len++;
        end
      end
      KIND_POP, KIND_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // A delete at or past the end simply drops the last entry.
          if (req.kind == KIND_DELETE && at < list_len) begin
            for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          end
          list_len--;
        end
      end
      KIND_READ: begin
        if (at < list_len && at < CAPACITY) res.read_value = list_words[at];
        else res.status = ST_RANGE;
      end
      default: begin
      end
    endcase
    res.count = list_len[COUNT_W-1:0];
    res.is_empty = (list_len == 0);
    return res;
  endfunction

  // Adds a request to the plan and keeps the planned length in step.
  task automatic plan_request(kind_t kind, int pos, logic [VAL_W-1:0] word);
    in_req_t req;
    req.kind = kind;
    req.position = pos[POS_W-1:0];
    req.value = word;
    queued_requests.push_back(req);
    if (kind == KIND_PUSH || kind == KIND_INSERT) begin
      if (planned_len < CAPACITY) planned_len++;
    end else if (kind == KIND_POP || kind == KIND_DELETE) begin
      if (planned_len > 0) planned_len--;
    end
  endtask

  // Driver. At each rising edge it first notes whether the request on the
  // ports was taken, then decides what to present for the next cycle. A
  // request stays on the ports until taken. At each edge the ports are left idle
  // with a chance of roughly 29 in a hundred, except over a stretch in the middle
  // of the run where requests follow back to back.
  always @(posedge clk) begin : drive_requests
    logic quiet;
    logic idle_now;
    if (rst_n && start && !busy) begin
      due_responses.push_back(apply_to_list(in_req));
      accepted_n++;
    end
    quiet = (accepted_n >= 250 && accepted_n < 350);
    idle_now = !quiet && ($urandom_range(0, 99) < 29);
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Held: the same request stays on the ports.
    end else if (queued_requests.size() != 0 && !idle_now) begin
      start  <= 1'b1;
      in_req <= queued_requests.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor. Every result is taken in the cycle it is shown, since the
  // receiver cannot hold results off, and checked against the oldest
  // response owed. Anything but a clean low on out_valid counts as a result,
  // so an unknown strobe is caught too.
  always @(posedge clk) begin : check_responses
    out_res_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (due_responses.size() == 0) begin
        mismatch_n++;
        $display("%0t: result with none expected, actual %h (valid %b)",
                 $time, out_res, out_valid);
      end else begin
        want = due_responses.pop_front();
        if (out_valid !== 1'b1 ||
            out_res.status !== want.status ||
            out_res.read_value !== want.read_value ||
            out_res.count !== want.count ||
            out_res.is_empty !== want.is_empty) begin
          mismatch_n++;
          $display("%0t: mismatch, expected status %0d value %h count %0d empty %b,",
                   $time, want.status, want.read_value, want.count, want.is_empty);
          $display("%0t:          actual   status %0d value %h count %0d empty %b",
                   $time, out_res.status, out_res.read_value, out_res.count,
                   out_res.is_empty);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int phase;
    int pick;
    int pos;
    kind_t kind;
    logic [VAL_W-1:0] word;

    // Directed opening: rejections on an empty list, both edges of the value
    // range, inserts at the front, in the middle and past the end, reads at
    // the last entry, at exactly the count and far beyond it, and deletes in
    // the middle, at the last entry and past the end.
    plan_request(KIND_POP, 0, '0);
    plan_request(KIND_DELETE, 0, '0);
    plan_request(KIND_READ, 0, '0);
    plan_request(KIND_READ, 255, '0);
    plan_request(KIND_PUSH, 0, 32'h0000_0000);
    plan_request(KIND_PUSH, 255, 32'hFFFF_FFFF);
    plan_request(KIND_INSERT, 0, 32'hA5C3_0F96);
    plan_request(KIND_INSERT, 1, 32'h5A3C_F069);
    plan_request(KIND_INSERT, 255, 32'h1234_5678);
    plan_request(KIND_READ, 0, '0);
    plan_request(KIND_READ, 4, '0);
    plan_request(KIND_READ, 5, '0);
    plan_request(KIND_READ, 255, '0);
    plan_request(KIND_DELETE, 1, '0);
    plan_request(KIND_DELETE, 3, '0);
    plan_request(KIND_DELETE, 200, '0);
    plan_request(KIND_POP, 0, '0);
    plan_request(KIND_READ, 1, '0);

    // Random part in phases of forty: one that mostly fills the list and so
    // keeps running into the full case, one that mostly drains it into the
    // empty case, and one with every kind equally likely.
    for (n = 0; n < RANDOM_REQS; n++) begin
      phase = (n / 40) % 3;
      pick = $urandom_range(0, 99);
      if (phase == 0) begin
        kind = (pick < 40) ? KIND_PUSH : (pick < 80) ? KIND_INSERT :
               (pick < 88) ? KIND_READ : (pick < 94) ? KIND_POP : KIND_DELETE;
      end else if (phase == 1) begin
        kind = (pick < 35) ? KIND_POP : (pick < 75) ? KIND_DELETE :
               (pick < 85) ? KIND_READ : (pick < 93) ? KIND_PUSH : KIND_INSERT;
      end else begin
        kind = kind_t'($urandom_range(0, 4));
      end

      // Positions lean towards the live entries, with the end of the list and
      // the whole field range mixed in.
      pick = $urandom_range(0, 9);
      if (pick == 0) pos = $urandom_range(0, 255);
      else if (pick == 1) pos = 255;
      else if (pick == 2) pos = planned_len;
      else pos = $urandom_range(0, (planned_len > 0) ? planned_len - 1 : 0);

      pick = $urandom_range(0, 9);
      if (pick == 0) word = '0;
      else if (pick == 1) word = '1;
      else word = $urandom;

      plan_request(kind, pos, word);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last request to be taken and every response to arrive,
    // then keep watching the strobe so that any stray result is still seen.
    while (queued_requests.size() != 0 || start || due_responses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_n == 0 && due_responses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
